// File: rtl/core/polygon_area_perimeter_core_macros.svh
// Assertion macros used by the polygon area/perimeter port checker.
`ifndef POLYGON_AREA_PERIMETER_CORE_MACROS_SVH
`define POLYGON_AREA_PERIMETER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset
`define PAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define PAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/pap_pkg.sv
// Shared widths and types for the polygon area/perimeter core.
`default_nettype none

package pap_pkg;

  // coordinate and derived arithmetic widths
  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int TERM_BITS  = PROD_BITS + 1;

  // accumulator and result widths
  localparam int AREA_BITS = 48;
  localparam int DA_BITS   = 47;
  localparam int LEN_BITS  = 40;

  // stream packing
  localparam int IN_TDATA_W  = 2 * COORD_BITS;
  localparam int OUT_TDATA_W = ((DA_BITS + LEN_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [DIFF_BITS-1:0]         mag_t;
  typedef logic [PROD_BITS-1:0]         prod_t;

endpackage

`default_nettype wire

// File: rtl/core/pap_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module pap_mul #(
  parameter int W = 17
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic                done,
  output logic [2*W-1:0]      p
);

  localparam int CW = $clog2(W);

  logic [2*W-1:0] p_r;
  logic [W-1:0]   a_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [W:0]     sum;
  logic [2*W-1:0] p_nxt;

  // add the multiplicand into the high half when the current bit is set
  always_comb begin
    sum   = {1'b0, p_r[2*W-1:W]} + {1'b0, (p_r[0] ? a_r : {W{1'b0}})};
    p_nxt = {sum, p_r[W-1:1]};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // product shift register, multiplier held in the low half
  always_ff @(posedge clk) begin
    if (start) begin
      p_r <= {{W{1'b0}}, b};
      a_r <= a;
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

`default_nettype wire

// File: rtl/core/pap_isqrt.sv
// Digit-serial integer square root: one base-4 digit of the operand per cycle.
`default_nettype none

module pap_isqrt #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       start,
  input  wire pap_pkg::prod_t                             d2,
  output logic                                            done,
  output logic [pap_pkg::PROD_BITS/2 + FRAC_BITS - 1:0]   root
);

  // integer digit pairs, then fraction digits fed with zeros
  localparam int ND   = pap_pkg::PROD_BITS / 2 + FRAC_BITS;
  localparam int RW   = ND;
  localparam int REMW = ND + 2;
  localparam int CW   = $clog2(ND);

  pap_pkg::prod_t  d_r;
  logic [REMW-1:0] rem_r;
  logic [RW-1:0]   root_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            ge;
  logic [REMW-1:0] rem_nxt;
  logic [RW-1:0]   root_nxt;

  // one restoring step
  always_comb begin
    rem_sh   = {rem_r[REMW-3:0], d_r[pap_pkg::PROD_BITS-1 -: 2]};
    trial    = {root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[RW-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ND - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand shift register, remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      d_r    <= d2;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      d_r    <= {d_r[pap_pkg::PROD_BITS-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// File: rtl/core/polygon_area_perimeter_core.sv
// Top level: streaming shoelace area and perimeter of a polygon.
//
//  channel | direction | tdata fields (low bit up)                    | tlast
//  in_     | slave     | x_coord[15:0], y_coord[31:16]                | last_vertex
//  out_    | master    | double_area[46:0], perimeter_length[86:47]   | -
//
// Each edge runs setup (S_PREP), the bit-serial multipliers (S_MUL), the
// hand-off (S_RST), the digit-serial square root (S_ROOT) and accumulation
// (S_ACC). A vertex is taken in S_IDLE; a middle vertex then runs one edge;
// the last vertex its edge and the closing edge (only the closing edge,
// zero-length, if also the first), then S_EMIT loads the result register.
// Synchronous active-low reset clears the state.
// A result waiting in the output register does not block input; only a
// second result stalls until the first is taken.
`default_nettype none

module polygon_area_perimeter_core #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // x_coord [15:0], y_coord [31:16]
  input  wire logic [pap_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                               in_tlast,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // double_area [46:0], perimeter_length [86:47], zero pad [87]
  output logic [pap_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready
);

  localparam int ROOT_BITS = pap_pkg::PROD_BITS / 2 + FRAC_BITS;
  localparam int AB        = pap_pkg::AREA_BITS;
  localparam int LB        = pap_pkg::LEN_BITS;
  localparam int DB        = pap_pkg::DA_BITS;
  localparam int TB        = pap_pkg::TERM_BITS;
  localparam int PAD_BITS  = pap_pkg::OUT_TDATA_W - DB - LB;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_RST,
    S_ROOT,
    S_ACC,
    S_EMIT
  } state_t;

  state_t state_r;

  // control and accumulators
  logic                    have_vertex_r;
  logic                    closing_r;
  logic                    pend_close_r;
  logic signed [AB-1:0]    area_r;
  logic [LB-1:0]           len_r;
  logic                    out_valid_r;

  // datapath payload
  pap_pkg::coord_t         first_x_r, first_y_r, prev_x_r, prev_y_r;
  pap_pkg::coord_t         ea_x_r, ea_y_r, eb_x_r, eb_y_r;
  logic                    term_neg_r;
  logic signed [TB-1:0]    term_r;
  logic [DB-1:0]           out_da_r;
  logic [LB-1:0]           out_len_r;

  pap_pkg::coord_t         in_x, in_y;
  logic                    in_fire;
  logic                    emit_fire;

  pap_pkg::diff_t          dx, dy, sy;
  pap_pkg::mag_t           dx_mag, dy_mag, sy_mag;
  pap_pkg::prod_t          p_term, p_xx, p_yy;
  logic                    mul_done;
  logic                    mul_done_term, mul_done_xx, mul_done_yy;
  logic                    mul_start;
  logic                    root_start;
  logic                    root_done;
  logic [ROOT_BITS-1:0]    root;
  pap_pkg::prod_t          d2;

  logic signed [AB:0]      area_sum;
  logic signed [AB-1:0]    area_sat;
  logic [LB:0]             len_sum;
  logic [LB-1:0]           len_sat;
  logic signed [AB-1:0]    area_neg;
  logic [DB-1:0]           area_abs;

  assign in_x      = in_tdata[pap_pkg::COORD_BITS-1:0];
  assign in_y      = in_tdata[pap_pkg::IN_TDATA_W-1:pap_pkg::COORD_BITS];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // edge differences and magnitudes for the multipliers
  always_comb begin
    dx     = pap_pkg::diff_t'(ea_x_r) - pap_pkg::diff_t'(eb_x_r);
    dy     = pap_pkg::diff_t'(ea_y_r) - pap_pkg::diff_t'(eb_y_r);
    sy     = pap_pkg::diff_t'(ea_y_r) + pap_pkg::diff_t'(eb_y_r);
    dx_mag = dx[pap_pkg::DIFF_BITS-1] ? pap_pkg::mag_t'(-dx) : pap_pkg::mag_t'(dx);
    dy_mag = dy[pap_pkg::DIFF_BITS-1] ? pap_pkg::mag_t'(-dy) : pap_pkg::mag_t'(dy);
    sy_mag = sy[pap_pkg::DIFF_BITS-1] ? pap_pkg::mag_t'(-sy) : pap_pkg::mag_t'(sy);
  end

  assign mul_start  = (state_r == S_PREP);
  assign root_start = (state_r == S_RST);
  assign d2         = p_xx + p_yy;
  assign mul_done   = mul_done_term & mul_done_xx & mul_done_yy;

  // shoelace term and the two squares run side by side
  pap_mul #(.W(pap_pkg::DIFF_BITS)) u_mul_term (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (dx_mag),
    .b     (sy_mag),
    .done  (mul_done_term),
    .p     (p_term)
  );

  pap_mul #(.W(pap_pkg::DIFF_BITS)) u_mul_xx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (dx_mag),
    .b     (dx_mag),
    .done  (mul_done_xx),
    .p     (p_xx)
  );

  pap_mul #(.W(pap_pkg::DIFF_BITS)) u_mul_yy (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (dy_mag),
    .b     (dy_mag),
    .done  (mul_done_yy),
    .p     (p_yy)
  );

  pap_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .d2    (d2),
    .done  (root_done),
    .root  (root)
  );

  // saturating accumulation
  always_comb begin
    area_sum = {area_r[AB-1], area_r} + (AB+1)'(term_r);
    if (area_sum[AB] != area_sum[AB-1]) begin
      area_sat = area_sum[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
    end else begin
      area_sat = area_sum[AB-1:0];
    end
    len_sum = {1'b0, len_r} + (LB+1)'(root);
    len_sat = len_sum[LB] ? {LB{1'b1}} : len_sum[LB-1:0];
  end

  // absolute area, the most negative sum clamps to the positive limit
  always_comb begin
    area_neg = -area_r;
    if (!area_r[AB-1]) begin
      area_abs = area_r[DB-1:0];
    end else if (area_r == {1'b1, {(AB-1){1'b0}}}) begin
      area_abs = {DB{1'b1}};
    end else begin
      area_abs = area_neg[DB-1:0];
    end
  end

  // sequencer, accumulators and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      have_vertex_r <= 1'b0;
      closing_r     <= 1'b0;
      pend_close_r  <= 1'b0;
      area_r        <= '0;
      len_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (have_vertex_r) begin
              closing_r    <= 1'b0;
              pend_close_r <= in_tlast;
              state_r      <= S_PREP;
            end else begin
              have_vertex_r <= 1'b1;
              if (in_tlast) begin
                closing_r    <= 1'b1;
                pend_close_r <= 1'b0;
                state_r      <= S_PREP;
              end
            end
          end
        end
        S_PREP: state_r <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            state_r <= S_RST;
          end
        end
        S_RST: state_r <= S_ROOT;
        S_ROOT: begin
          if (root_done) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          area_r <= area_sat;
          len_r  <= len_sat;
          if (closing_r) begin
            state_r <= S_EMIT;
          end else if (pend_close_r) begin
            closing_r    <= 1'b1;
            pend_close_r <= 1'b0;
            state_r      <= S_PREP;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            area_r        <= '0;
            len_r         <= '0;
            have_vertex_r <= 1'b0;
            closing_r     <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // vertex, edge and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (have_vertex_r) begin
        ea_x_r <= prev_x_r;
        ea_y_r <= prev_y_r;
      end else begin
        ea_x_r    <= in_x;
        ea_y_r    <= in_y;
        first_x_r <= in_x;
        first_y_r <= in_y;
      end
      eb_x_r   <= in_x;
      eb_y_r   <= in_y;
      prev_x_r <= in_x;
      prev_y_r <= in_y;
    end
    // closing edge runs from the last vertex back to the first
    if ((state_r == S_ACC) && !closing_r && pend_close_r) begin
      ea_x_r <= prev_x_r;
      ea_y_r <= prev_y_r;
      eb_x_r <= first_x_r;
      eb_y_r <= first_y_r;
    end
    if (state_r == S_PREP) begin
      term_neg_r <= dx[pap_pkg::DIFF_BITS-1] ^ sy[pap_pkg::DIFF_BITS-1];
    end
    if (state_r == S_RST) begin
      term_r <= term_neg_r ? -TB'(p_term) : TB'(p_term);
    end
    if (emit_fire) begin
      out_da_r  <= area_abs;
      out_len_r <= len_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_BITS{1'b0}}, out_len_r, out_da_r};

endmodule

`default_nettype wire

// File: rtl/core/pap_checker.sv
// Port-level checker for the polygon area/perimeter core, bound to the top.
`default_nettype none

`include "polygon_area_perimeter_core_macros.svh"

module pap_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            in_tlast,
  input wire logic [pap_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready
);

  // no result is pending right after reset
  `PAP_ASSERT_ALWAYS(a_rst_out_idle, !rst_n |=> !out_tvalid, "result valid after reset")

  // a stalled result stays and keeps its data
  `PAP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // the core goes busy once a polygon ends
  `PAP_ASSERT(a_last_busy, in_tvalid && in_tready && in_tlast |=> !in_tready, "input open after last vertex")

  // a new result only comes out of the busy phase
  `PAP_ASSERT(a_rise_from_busy, $rose(out_tvalid) |-> !$past(in_tready), "result without closing work")

endmodule

bind polygon_area_perimeter_core pap_checker u_pap_checker (.*);

`default_nettype wire

// File: tb/polygon_area_perimeter_checker.sv
// Checker: watches both stream channels, predicts each polygon result and compares.
`default_nettype none

module polygon_area_perimeter_checker #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // x_coord [15:0], y_coord [31:16]
  input  wire logic [pap_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                           in_tlast,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  // double_area [46:0], perimeter_length [86:47], zero pad [87]
  input  wire logic [pap_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  output int                                  fail_count,
  output int                                  pending
);

  localparam int DA_BITS    = pap_pkg::DA_BITS;
  localparam int LEN_BITS   = pap_pkg::LEN_BITS;
  localparam int COORD_BITS = pap_pkg::COORD_BITS;
  localparam longint AREA_HI = (longint'(1) << DA_BITS) - 1;
  localparam longint AREA_LO = -AREA_HI - 1;
  localparam longint unsigned LEN_HI = (64'd1 << LEN_BITS) - 1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DA_BITS-1:0]  double_area;
    logic [LEN_BITS-1:0] perimeter;
  } polygon_result_t;

  // predicted polygon state
  pap_pkg::coord_t first_x, first_y, prev_x, prev_y;
  bit              holding_vertex;
  longint          area_acc;
  longint unsigned perim_acc;
  polygon_result_t expected_results[$];

  initial begin
    fail_count = 0;
    pending = 0;
    holding_vertex = 1'b0;
    area_acc = 0;
    perim_acc = 0;
  end

  // floor(sqrt(d2) * 2^FRAC_BITS), built bit by bit from the top
  function automatic longint unsigned scaled_root(input longint unsigned d2);
    longint unsigned val, est, trial;
    int b;
    val = d2 << (2 * FRAC_BITS);
    est = 0;
    for (b = 31; b >= 0; b--) begin
      trial = est | (64'd1 << b);
      if (trial * trial <= val) est = trial;
    end
    return est;
  endfunction

  // shoelace term and edge length of one edge, both sums clamped
  task automatic add_edge(input pap_pkg::coord_t xa, input pap_pkg::coord_t ya,
                          input pap_pkg::coord_t xb, input pap_pkg::coord_t yb);
    longint dx, dy, sum;
    longint unsigned len;
    dx = longint'(xa) - longint'(xb);
    dy = longint'(ya) - longint'(yb);
    sum = area_acc + dx * (longint'(ya) + longint'(yb));
    if (sum > AREA_HI) sum = AREA_HI;
    if (sum < AREA_LO) sum = AREA_LO;
    area_acc = sum;
    len = scaled_root(longint'(dx * dx) + longint'(dy * dy));
    if (len > LEN_HI) len = LEN_HI;
    perim_acc = perim_acc + len;
    if (perim_acc > LEN_HI) perim_acc = LEN_HI;
  endtask

  // one accepted vertex; the last one closes the polygon and queues its result
  task automatic take_vertex(input pap_pkg::coord_t x, input pap_pkg::coord_t y,
                             input bit last);
    polygon_result_t res;
    if (!holding_vertex) begin
      first_x = x;
      first_y = y;
      holding_vertex = 1'b1;
    end else begin
      add_edge(prev_x, prev_y, x, y);
    end
    prev_x = x;
    prev_y = y;
    if (last) begin
      add_edge(x, y, first_x, first_y);
      if (area_acc < 0)
        res.double_area = (area_acc == AREA_LO) ? AREA_HI[DA_BITS-1:0]
                                                : DA_BITS'(-area_acc);
      else
        res.double_area = DA_BITS'(area_acc);
      res.perimeter = LEN_BITS'(perim_acc);
      expected_results.push_back(res);
      holding_vertex = 1'b0;
      area_acc = 0;
      perim_acc = 0;
      first_x = '0;
      first_y = '0;
      prev_x = '0;
      prev_y = '0;
    end
  endtask

  task automatic report_field(input string field, input longint unsigned exp_v,
                              input longint unsigned act_v);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, exp_v,
               act_v);
  endtask

  // sample both channels at each edge
  always @(posedge clk) begin
    polygon_result_t want;
    logic [DA_BITS-1:0]  got_area;
    logic [LEN_BITS-1:0] got_perim;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        take_vertex(pap_pkg::coord_t'(in_tdata[COORD_BITS-1:0]),
                    pap_pkg::coord_t'(in_tdata[2*COORD_BITS-1:COORD_BITS]), in_tlast);
      if (out_tvalid && out_tready) begin
        got_area  = out_tdata[DA_BITS-1:0];
        got_perim = out_tdata[DA_BITS +: LEN_BITS];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t unexpected result transaction: area %0d perimeter %0d",
                     $realtime, got_area, got_perim);
        end else begin
          want = expected_results.pop_front();
          if (got_area !== want.double_area)
            report_field("double_area", want.double_area, got_area);
          if (got_perim !== want.perimeter)
            report_field("perimeter_length", want.perimeter, got_perim);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

`default_nettype wire

// File: tb/polygon_area_perimeter_core_test.sv
// Testbench top: clock, reset, vertex stimulus, receiver stalls and the verdict.
`default_nettype none

module polygon_area_perimeter_core_test;

  localparam int FRAC = 8;
  localparam int EDGE_CYCLES = 39 + FRAC;
  localparam int TAIL_CYCLES = 4 * EDGE_CYCLES;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 210;

  typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_CORNER, SPREAD_MIXED} spread_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [pap_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tlast = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pap_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  polygon_area_perimeter_core #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  polygon_area_perimeter_checker #(.FRAC_BITS(FRAC)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("polygon_area_perimeter_core_test: FAIL");
      $finish;
    end
  end

  // one vertex transaction, with an optional idle gap before it
  task automatic send_vertex(input pap_pkg::coord_t x, input pap_pkg::coord_t y,
                             input bit last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_tdata  <= {y, x};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic pap_pkg::coord_t pick_coord(input spread_t spread);
    spread_t s;
    s = (spread == SPREAD_MIXED) ? spread_t'($urandom_range(0, 2)) : spread;
    case (s)
      SPREAD_NEAR:   return pap_pkg::coord_t'(int'($urandom_range(0, 100)) - 50);
      SPREAD_CORNER: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default:       return pap_pkg::coord_t'($urandom);
    endcase
  endfunction

  // random polygons, mostly short, a few long; each one is closed
  task automatic run_polygons(input int n_items);
    int sent, len, k;
    spread_t spread;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      spread = spread_t'($urandom_range(0, 3));
      for (k = 0; k < len; k++)
        send_vertex(pick_coord(spread), pick_coord(spread), k == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single vertex polygons give zero
    send_vertex(16'sh7fff, 16'sh8000, 1'b1);
    send_vertex(16'sh0000, 16'sh0000, 1'b1);
    // two vertices: edge counted both ways, longest possible edge
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b1);
    // full-range square
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
    send_vertex(16'sh8000, 16'sh7fff, 1'b1);
    // clockwise triangle, negative shoelace sum
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd100, 1'b0);
    send_vertex(16'sd100, 16'sd0, 1'b1);
    // repeated vertex, zero-length edges
    send_vertex(16'sd5, 16'sd5, 1'b0);
    send_vertex(16'sd5, 16'sd5, 1'b0);
    send_vertex(16'sd5, 16'sd5, 1'b1);
    // small triangle around the origin
    send_vertex(-16'sd1, -16'sd1, 1'b0);
    send_vertex(16'sd1, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1, 1'b1);

    run_polygons(PHASE_ITEMS);
    send_idle_pct = 65;
    stall_pct = 0;
    run_polygons(PHASE_ITEMS);
    send_idle_pct = 0;
    stall_pct = 65;
    run_polygons(PHASE_ITEMS);
    send_idle_pct = 23;
    stall_pct = 23;
    run_polygons(PHASE_ITEMS);
    in_tvalid <= 1'b0;

    // drain, then give the core time to show any stray transaction
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("polygon_area_perimeter_core_test: PASS");
    else
      $display("polygon_area_perimeter_core_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: polygon_area_perimeter_core.f
+incdir+rtl/core
rtl/core/pap_pkg.sv
rtl/core/pap_mul.sv
rtl/core/pap_isqrt.sv
rtl/core/polygon_area_perimeter_core.sv
rtl/core/pap_checker.sv
tb/polygon_area_perimeter_checker.sv
tb/polygon_area_perimeter_core_test.sv
